### sv/tcw_pkg.sv
// Package for the text console character writer: payload types, codes and defaults.
package tcw_pkg;

  localparam int COLS_DEF = 80;
  localparam int ROWS_DEF = 25;

  // Width of the flat cursor field in a result transfer.
  localparam int OUT_POS_W = 11;

  // Function codes of an input transfer.
  localparam logic [1:0] FUNC_PUT  = 2'd0;
  localparam logic [1:0] FUNC_SET  = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  // Control characters and the blanking character.
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_SPACE = 8'd32;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] char_code;
    logic [7:0] attr;
    logic [6:0] col;
    logic [4:0] row;
  } in_item_t;

  typedef struct packed {
    logic [OUT_POS_W-1:0] flat_cursor;
    logic [7:0]           cell_char;
    logic [7:0]           cell_attr;
    logic                 scrolled;
  } out_item_t;

endpackage

### sv/tcw_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/text_console_char_writer_unit.sv
// Text console character writer: screen store of character cells with a cursor and scrolling.
// Steps: a plain character, control code or unused function passes through the execute state
// to the done state, which makes the result transfer; a cell read adds a read state; setting the
// cursor adds a column reduction state that repeats once for every COLS the column is reduced by.
// A scroll adds a move pass and a fill pass, in which the single RAM port pair moves one cell a
// cycle. One item is in work at a time. After reset the block clears every cell with in_stall_o high.
module text_console_char_writer_unit #(
  parameter int COLS = tcw_pkg::COLS_DEF,
  parameter int ROWS = tcw_pkg::ROWS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Configuration: auto-scroll enable.
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  // Input channel.
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  tcw_pkg::in_item_t  in_i,
  // Result channel.
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output tcw_pkg::out_item_t out_o
);

  // Geometry. The cursor runs from 0 to CELLS inclusive, CELLS being the saturated position.
  localparam int CELLS = COLS * ROWS;
  localparam int PosW  = $clog2(CELLS + 1);
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLS);

  localparam logic [PosW-1:0] CellsP    = PosW'(CELLS);
  localparam logic [PosW-1:0] LastCell  = PosW'(CELLS - 1);
  localparam logic [PosW-1:0] MoveLast  = PosW'(CELLS - COLS);
  localparam logic [PosW:0]   CellsX    = (PosW + 1)'(CELLS);
  localparam logic [CW-1:0]   LastCol   = CW'(COLS - 1);

  // Sequencer states.
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_COLDIV = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_MOVE   = 3'd5;
  localparam logic [2:0] S_FILL   = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]         state_q, state_d;
  logic [PosW-1:0]    cnt_q, cnt_d;
  logic [PosW-1:0]    cursor_q, cursor_d;
  logic [CW-1:0]      col_q, col_d;
  logic [6:0]         colw_q, colw_d;
  logic               auto_q, auto_d;
  logic               out_valid_q, out_valid_d;
  tcw_pkg::in_item_t  item_q, item_d;
  tcw_pkg::out_item_t out_q, out_d;
  logic [7:0]         rchar_q, rchar_d;
  logic [7:0]         rattr_q, rattr_d;
  logic               scr_q, scr_d;

  // Screen store ports.
  logic               ram_we;
  logic [PosW-1:0]    ram_waddr;
  logic [15:0]        ram_wdata;
  logic [PosW-1:0]    ram_raddr;
  logic [15:0]        ram_rdata;

  // Character placement results, valid while executing a put.
  logic [PosW-1:0]    np;
  logic [CW-1:0]      nc;
  logic [PosW:0]      pos_inc;
  logic [PosW:0]      pos_lf;
  logic               pw_we;
  logic [PosW-1:0]    pw_addr;
  logic [15:0]        pw_data;
  logic               do_scroll;

  // Cursor placement from column and row.
  logic [31:0]        set_flat;
  logic [PosW-1:0]    set_sat;

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr[AW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // A new item is only taken when the sequencer is free; the result register
  // is separate, so a finished result may still be waiting downstream.
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Work out where a put leaves the cursor and which cell, if any, it writes.
  // The column register tracks the cursor modulo COLS, so no division is needed here.
  assign pos_inc = {1'b0, cursor_q} + (PosW + 1)'(1);
  assign pos_lf  = {1'b0, cursor_q} + (PosW + 1)'(COLS) - (PosW + 1)'(col_q);

  always_comb begin
    np      = cursor_q;
    nc      = col_q;
    pw_we   = 1'b0;
    pw_addr = cursor_q;
    pw_data = {item_q.attr, item_q.char_code};
    case (item_q.char_code)
      tcw_pkg::CH_CR: begin
        np = cursor_q - PosW'(col_q);
        nc = '0;
      end
      tcw_pkg::CH_LF: begin
        np = (pos_lf > CellsX) ? CellsP : pos_lf[PosW-1:0];
        nc = '0;
      end
      tcw_pkg::CH_BS: begin
        // Stepping back always lands inside the store, so the blank is written whenever the cursor is not zero.
        if (cursor_q != '0) begin
          np      = cursor_q - PosW'(1);
          nc      = (col_q == '0) ? LastCol : col_q - CW'(1);
          pw_we   = 1'b1;
          pw_addr = cursor_q - PosW'(1);
          pw_data = {item_q.attr, tcw_pkg::CH_SPACE};
        end
      end
      default: begin
        // A character at the saturated position is dropped.
        pw_we = (cursor_q < CellsP);
        if (pos_inc > CellsX) begin
          np = CellsP;
          nc = '0;
        end else begin
          np = pos_inc[PosW-1:0];
          nc = (col_q == LastCol) ? '0 : col_q + CW'(1);
        end
      end
    endcase
  end

  assign do_scroll = (np == CellsP) && auto_q;

  assign set_flat = 32'(item_q.row) * 32'(COLS) + 32'(item_q.col);
  assign set_sat  = (set_flat > 32'(CELLS)) ? CellsP : set_flat[PosW-1:0];

  // Store port steering. During a scroll the read runs one row ahead of the
  // write, and the write address trails the read count by one to match the registered read data.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt_q;
    ram_wdata = '0;
    ram_raddr = cursor_q;
    case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_EXEC: begin
        if (item_q.func == tcw_pkg::FUNC_PUT) begin
          ram_we    = pw_we;
          ram_waddr = pw_addr;
          ram_wdata = pw_data;
        end
      end
      S_MOVE: begin
        ram_raddr = cnt_q + PosW'(COLS);
        ram_we    = (cnt_q != '0);
        ram_waddr = cnt_q - PosW'(1);
        ram_wdata = ram_rdata;
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = {item_q.attr, tcw_pkg::CH_SPACE};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cursor_d    = cursor_q;
    col_d       = col_q;
    colw_d      = colw_q;
    auto_d      = auto_q;
    out_valid_d = out_valid_q;
    item_d      = item_q;
    out_d       = out_q;
    rchar_d     = rchar_q;
    rattr_d     = rattr_q;
    scr_d       = scr_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cfg_we_i) begin
      auto_d = cfg_wdata_i;
    end

    case (state_q)
      S_CLEAR: begin
        cnt_d = cnt_q + PosW'(1);
        if (cnt_q == LastCell) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        rchar_d = '0;
        rattr_d = '0;
        scr_d   = 1'b0;
        case (item_q.func)
          tcw_pkg::FUNC_PUT: begin
            cursor_d = np;
            col_d    = nc;
            state_d  = S_DONE;
            if (do_scroll) begin
              cursor_d = MoveLast;
              col_d    = '0;
              scr_d    = 1'b1;
              cnt_d    = '0;
              state_d  = S_MOVE;
            end
          end
          tcw_pkg::FUNC_SET: begin
            cursor_d = set_sat;
            colw_d   = item_q.col;
            state_d  = S_COLDIV;
          end
          tcw_pkg::FUNC_READ: begin
            state_d = (cursor_q < CellsP) ? S_READ : S_DONE;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_COLDIV: begin
        // Repeated subtraction brings the given column into range.
        if (32'(colw_q) >= 32'(COLS)) begin
          colw_d = colw_q - 7'(COLS);
        end else begin
          col_d   = (cursor_q == CellsP) ? '0 : CW'(colw_q);
          state_d = S_DONE;
        end
      end
      S_READ: begin
        rchar_d = ram_rdata[7:0];
        rattr_d = ram_rdata[15:8];
        state_d = S_DONE;
      end
      S_MOVE: begin
        if (cnt_q == MoveLast) begin
          state_d = S_FILL;
        end else begin
          cnt_d = cnt_q + PosW'(1);
        end
      end
      S_FILL: begin
        cnt_d = cnt_q + PosW'(1);
        if (cnt_q == LastCell) begin
          cnt_d   = '0;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d          = 1'b1;
          out_d.flat_cursor    = tcw_pkg::OUT_POS_W'(cursor_q);
          out_d.cell_char      = rchar_q;
          out_d.cell_attr      = rattr_q;
          out_d.scrolled       = scr_q;
          state_d              = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      cursor_q    <= '0;
      col_q       <= '0;
      auto_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cursor_q    <= cursor_d;
      col_q       <= col_d;
      auto_q      <= auto_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    colw_q  <= colw_d;
    item_q  <= item_d;
    out_q   <= out_d;
    rchar_q <= rchar_d;
    rattr_q <= rattr_d;
    scr_q   <= scr_d;
  end

  // The cursor never passes the saturated position.
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= CellsP)
    else $error("cursor beyond the cell count");

  // The column register stays a valid column.
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < 32'(COLS))
    else $error("column register out of range");

  // An input transfer always starts execution in the following cycle.
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_EXEC))
    else $error("accepted item not executed");

  // Every cycle of the last-row fill writes one blank cell.
  a_fill_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL) |-> ram_we)
    else $error("fill cycle without a store write");

endmodule
